// ===== hdl/tile_map_rect_collision_defines.svh =====
// ----------------------------------------------------------------------------
// tile_map_rect_collision_defines
// Assertion macros shared by the tile map collision RTL.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_RECT_COLLISION_DEFINES_SVH
`define TILE_MAP_RECT_COLLISION_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define TMRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile map collision: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define TMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile map collision: next-cycle check failed");

`endif

// ===== hdl/tmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmrc_pkg
// Widths, defaults, register codes and shared types of the tile map block.
// ----------------------------------------------------------------------------
package tmrc_pkg;

    // Parameter defaults
    localparam int TILE_SHIFT_DEF = 5;
    localparam int MAX_ROWS_DEF   = 32;
    localparam int MAX_COLS_DEF   = 256;

    // Field widths
    localparam int ROWS_W = 6;
    localparam int COLS_W = 9;
    localparam int CNT_W  = 9;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 12;
    localparam int EDGE_W = 18;
    localparam int TROW_W = 5;
    localparam int TCOL_W = 8;
    localparam int TID_W  = 16;

    // Register reset values
    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd23;
    localparam logic [COLS_W-1:0] COLS_RESET = 9'd240;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_BIT = 2;
    localparam logic REG_ROWS_USED = 1'b0;
    localparam logic REG_COLS_USED = 1'b1;

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    // Clamped tile span of one axis
    typedef struct packed {
        logic signed [EDGE_W-1:0] lo;
        logic signed [EDGE_W-1:0] hi;
        logic                     empty;
    } t_span;

endpackage

// ===== hdl/tmrc_ram.sv =====
// ----------------------------------------------------------------------------
// tmrc_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tmrc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tmrc_axis.sv =====
// ----------------------------------------------------------------------------
// tmrc_axis
// Edge unit: turns a pixel edge pair into a tile span clamped to the map.
// ----------------------------------------------------------------------------
module tmrc_axis #(
    parameter int TILE_SHIFT = tmrc_pkg::TILE_SHIFT_DEF
) (
    input  logic signed [tmrc_pkg::POS_W-1:0]  i_pos,
    input  logic        [tmrc_pkg::SIZE_W-1:0] i_size,
    input  logic        [tmrc_pkg::CNT_W-1:0]  i_count,
    output tmrc_pkg::t_span                    o_span
);

    localparam int EW = tmrc_pkg::EDGE_W;
    localparam logic signed [EW-1:0] BIAS = EW'((1 << TILE_SHIFT) - 1);
    localparam logic signed [EW-1:0] ONE  = EW'(1);

    logic signed [EW-1:0] pos_e;
    logic signed [EW-1:0] end_e;
    logic signed [EW-1:0] q_lo;
    logic signed [EW-1:0] q_hi;
    logic signed [EW-1:0] cnt_m1;
    logic signed [EW-1:0] lo_c;
    logic signed [EW-1:0] hi_c;

    // Divide by the tile size, truncating toward zero
    function automatic logic signed [EW-1:0] div_tz(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] adj;
        adj = v[EW-1] ? (v + BIAS) : v;
        return adj >>> TILE_SHIFT;
    endfunction

    // Edges and quotients
    always_comb begin
        pos_e  = EW'(i_pos);
        end_e  = pos_e + signed'({{(EW - tmrc_pkg::SIZE_W){1'b0}}, i_size});
        q_lo   = div_tz(pos_e);
        q_hi   = div_tz(end_e);
        cnt_m1 = signed'({{(EW - tmrc_pkg::CNT_W){1'b0}}, i_count}) - ONE;
    end

    // Clamp to the map and flag an empty span
    always_comb begin
        lo_c = q_lo[EW-1] ? '0 : q_lo;
        hi_c = (q_hi > cnt_m1) ? cnt_m1 : q_hi;
        o_span.lo    = lo_c;
        o_span.hi    = hi_c;
        o_span.empty = (i_count == '0) || (lo_c > hi_c);
    end

endmodule

// ===== hdl/tile_map_rect_collision.sv =====
// ----------------------------------------------------------------------------
// tile_map_rect_collision: one-bit tile map with rectangle probe, one map read per cycle.
// Write word: taken in idle. Probe: X span, Y span, scan, drain, then the result state; an
// empty span skips the scan. Scan stops at the first hit; idle returns as the result word loads.
// Reset clears all MAX_ROWS*MAX_COLS (8192) map words first, with input stalled.
// ----------------------------------------------------------------------------
`include "tile_map_rect_collision_defines.svh"

module tile_map_rect_collision #(
    parameter int TILE_SHIFT = tmrc_pkg::TILE_SHIFT_DEF,
    parameter int MAX_ROWS   = tmrc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = tmrc_pkg::MAX_COLS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_action,
    input  logic        [tmrc_pkg::TROW_W-1:0]   i_tile_row,
    input  logic        [tmrc_pkg::TCOL_W-1:0]   i_tile_col,
    input  logic        [tmrc_pkg::TID_W-1:0]    i_tile_id,
    input  logic signed [tmrc_pkg::POS_W-1:0]    i_rect_x,
    input  logic signed [tmrc_pkg::POS_W-1:0]    i_rect_y,
    input  logic        [tmrc_pkg::SIZE_W-1:0]   i_rect_w,
    input  logic        [tmrc_pkg::SIZE_W-1:0]   i_rect_h,
    // result words
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [tmrc_pkg::PADDR_W-1:0]  paddr,
    input  logic        [tmrc_pkg::PDATA_W-1:0]  pwdata,
    output logic        [tmrc_pkg::PDATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = tmrc_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_AXIS_X,
        S_AXIS_Y,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state                               r_state;
    logic        [tmrc_pkg::ROWS_W-1:0]   r_rows_used;
    logic        [tmrc_pkg::COLS_W-1:0]   r_cols_used;
    logic        [AW-1:0]                 r_clr_addr;
    logic signed [tmrc_pkg::POS_W-1:0]    r_rect_x;
    logic signed [tmrc_pkg::POS_W-1:0]    r_rect_y;
    logic        [tmrc_pkg::SIZE_W-1:0]   r_rect_w;
    logic        [tmrc_pkg::SIZE_W-1:0]   r_rect_h;
    logic        [CW-1:0]                 r_col_hi;
    logic        [RW-1:0]                 r_row_lo;
    logic        [RW-1:0]                 r_row_hi;
    logic        [CW-1:0]                 r_col;
    logic        [RW-1:0]                 r_row;
    logic                                 r_empty_x;
    logic                                 r_pend;
    logic                                 r_hit_acc;
    logic                                 r_out_valid;
    logic                                 r_hit;

    logic                                 in_acc;
    logic                                 probe_acc;
    logic                                 out_acc;
    logic                                 cfg_wr;
    logic        [CNT_W-1:0]              rows_eff;
    logic        [CNT_W-1:0]              cols_eff;
    logic signed [tmrc_pkg::POS_W-1:0]    axis_pos;
    logic        [tmrc_pkg::SIZE_W-1:0]   axis_size;
    logic        [CNT_W-1:0]              axis_count;
    tmrc_pkg::t_span                      span;
    logic                                 row_ok;
    logic                                 col_ok;
    logic        [AW-1:0]                 wr_addr;
    logic        [AW-1:0]                 rd_addr;
    logic                                 ram_we;
    logic        [AW-1:0]                 ram_waddr;
    logic        [0:0]                    ram_wdata;
    logic        [0:0]                    ram_rdata;
    logic                                 scan_last;
    logic                                 scan_busy;
    logic                                 scan_in_range;

    // Handshakes
    assign in_acc    = i_valid && !o_stall;
    assign probe_acc = in_acc && (i_action == tmrc_pkg::ACT_PROBE);
    assign o_stall   = (r_state != S_IDLE);
    assign out_acc   = r_out_valid && !i_stall;
    assign o_valid   = r_out_valid;
    assign o_hit     = r_hit;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[tmrc_pkg::REG_BIT])
            tmrc_pkg::REG_ROWS_USED: prdata = tmrc_pkg::PDATA_W'(r_rows_used);
            tmrc_pkg::REG_COLS_USED: prdata = tmrc_pkg::PDATA_W'(r_cols_used);
            default:                 prdata = '0;
        endcase
    end

    // Active counts limited to the store
    assign rows_eff = (32'(r_rows_used) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                          : CNT_W'(r_rows_used);
    assign cols_eff = (32'(r_cols_used) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                          : CNT_W'(r_cols_used);

    // Share one edge unit between the column and row axes
    always_comb begin
        if (r_state == S_AXIS_Y) begin
            axis_pos   = r_rect_y;
            axis_size  = r_rect_h;
            axis_count = rows_eff;
        end else begin
            axis_pos   = r_rect_x;
            axis_size  = r_rect_w;
            axis_count = cols_eff;
        end
    end

    tmrc_axis #(
        .TILE_SHIFT (TILE_SHIFT)
    ) u_axis (
        .i_pos   (axis_pos),
        .i_size  (axis_size),
        .i_count (axis_count),
        .o_span  (span)
    );

    // Map addressing
    assign row_ok    = 32'(i_tile_row) < 32'(MAX_ROWS);
    assign col_ok    = 32'(i_tile_col) < 32'(MAX_COLS);
    assign wr_addr   = AW'(i_tile_row) * AW'(MAX_COLS) + AW'(i_tile_col);
    assign rd_addr   = AW'(r_row) * AW'(MAX_COLS) + AW'(r_col);
    assign scan_last = (r_row == r_row_hi) && (r_col == r_col_hi);

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = in_acc && (i_action == tmrc_pkg::ACT_WRITE) && row_ok && col_ok;
            ram_waddr = wr_addr;
            ram_wdata = (i_tile_id != '0);
        end
    end

    tmrc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Sequencer, configuration registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rows_used <= tmrc_pkg::ROWS_RESET;
            r_cols_used <= tmrc_pkg::COLS_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // take register writes
            if (cfg_wr) begin
                case (paddr[tmrc_pkg::REG_BIT])
                    tmrc_pkg::REG_ROWS_USED: r_rows_used <= pwdata[tmrc_pkg::ROWS_W-1:0];
                    tmrc_pkg::REG_COLS_USED: r_cols_used <= pwdata[tmrc_pkg::COLS_W-1:0];
                    default: ;
                endcase
            end

            // drop the result word once taken, unless a new one loads behind it
            if (out_acc && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (probe_acc) begin
                        r_rect_x <= i_rect_x;
                        r_rect_y <= i_rect_y;
                        r_rect_w <= i_rect_w;
                        r_rect_h <= i_rect_h;
                        r_state  <= S_AXIS_X;
                    end
                end
                S_AXIS_X: begin
                    r_col     <= span.lo[CW-1:0];
                    r_col_hi  <= span.hi[CW-1:0];
                    r_empty_x <= span.empty;
                    r_state   <= S_AXIS_Y;
                end
                S_AXIS_Y: begin
                    r_row     <= span.lo[RW-1:0];
                    r_row_lo  <= span.lo[RW-1:0];
                    r_row_hi  <= span.hi[RW-1:0];
                    r_hit_acc <= 1'b0;
                    r_pend    <= 1'b0;
                    r_state   <= (r_empty_x || span.empty) ? S_OUT : S_SCAN;
                end
                S_SCAN: begin
                    // stop at the first solid tile, else step row then column
                    if (r_pend && ram_rdata[0]) begin
                        r_hit_acc <= 1'b1;
                        r_pend    <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_pend <= 1'b1;
                        if (r_row == r_row_hi) begin
                            r_row <= r_row_lo;
                            r_col <= r_col + CW'(1);
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                        if (scan_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_pend    <= 1'b0;
                    r_hit_acc <= ram_rdata[0];
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_hit       <= r_hit_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    assign scan_busy     = (r_state == S_SCAN) || (r_state == S_DRAIN);
    assign scan_in_range = (r_col <= r_col_hi) && (r_row <= r_row_hi) && (r_row >= r_row_lo);

    `TMRC_ASSERT_IMPL(a_no_write_in_scan, i_clk, i_rst_n, scan_busy, !ram_we)
    `TMRC_ASSERT_NEXT(a_probe_starts, i_clk, i_rst_n, probe_acc, r_state == S_AXIS_X)
    `TMRC_ASSERT_IMPL(a_scan_bounds, i_clk, i_rst_n, r_state == S_SCAN, scan_in_range)
    `TMRC_ASSERT_IMPL(a_no_result_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !r_out_valid)

endmodule

// ===== verif/tile_map_rect_collision_tb.sv =====
// ----------------------------------------------------------------------------
// tile_map_rect_collision_tb
// Drives tile writes and rectangle probes into the collision block and holds
// its own copy of the solid map and the map size. Each probe's hit flag is
// predicted when the probe word is taken, and each result word is checked in
// order against it. Both sides idle at random. The run also includes a long
// receiver hold-off and map size changes made between idle phases.
// ----------------------------------------------------------------------------
module tile_map_rect_collision_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_PX       = 1 << tmrc_pkg::TILE_SHIFT_DEF;
    localparam int N_ROWS        = tmrc_pkg::MAX_ROWS_DEF;
    localparam int N_COLS        = tmrc_pkg::MAX_COLS_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_NS      = 100_000_000;
    localparam int PHASE_WORDS   = 175;

    typedef struct {
        logic                               action;
        logic [tmrc_pkg::TROW_W-1:0]        row;
        logic [tmrc_pkg::TCOL_W-1:0]        col;
        logic [tmrc_pkg::TID_W-1:0]         id;
        logic signed [tmrc_pkg::POS_W-1:0]  x;
        logic signed [tmrc_pkg::POS_W-1:0]  y;
        logic [tmrc_pkg::SIZE_W-1:0]        w;
        logic [tmrc_pkg::SIZE_W-1:0]        h;
    } t_tile_word;

    typedef struct {
        logic        hit;
        int unsigned probe_no;
    } t_hit_expect;

    logic                               i_clk;
    logic                               i_rst_n    = 1'b0;
    logic                               i_valid    = 1'b0;
    logic                               o_stall;
    logic                               i_action   = tmrc_pkg::ACT_WRITE;
    logic [tmrc_pkg::TROW_W-1:0]        i_tile_row = '0;
    logic [tmrc_pkg::TCOL_W-1:0]        i_tile_col = '0;
    logic [tmrc_pkg::TID_W-1:0]         i_tile_id  = '0;
    logic signed [tmrc_pkg::POS_W-1:0]  i_rect_x   = '0;
    logic signed [tmrc_pkg::POS_W-1:0]  i_rect_y   = '0;
    logic [tmrc_pkg::SIZE_W-1:0]        i_rect_w   = '0;
    logic [tmrc_pkg::SIZE_W-1:0]        i_rect_h   = '0;
    logic                               o_valid;
    logic                               i_stall    = 1'b0;
    logic                               o_hit;
    logic                               psel       = 1'b0;
    logic                               penable    = 1'b0;
    logic                               pwrite     = 1'b0;
    logic [tmrc_pkg::PADDR_W-1:0]       paddr      = '0;
    logic [tmrc_pkg::PDATA_W-1:0]       pwdata     = '0;
    logic [tmrc_pkg::PDATA_W-1:0]       prdata;
    logic                               pready;

    // Shadow state of the block
    logic [N_COLS-1:0]                  solid_tiles [N_ROWS];
    logic [tmrc_pkg::ROWS_W-1:0]        rows_cfg;
    logic [tmrc_pkg::COLS_W-1:0]        cols_cfg;
    t_hit_expect                        pending_hits [$];
    int unsigned                        probe_count = 0;
    int unsigned                        mismatches  = 0;

    // Idling control shared by both sides
    bit                                 calm    = 1'b0;
    int                                 rx_hold = 0;

    tile_map_rect_collision uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_tile_row (i_tile_row),
        .i_tile_col (i_tile_col),
        .i_tile_id  (i_tile_id),
        .i_rect_x   (i_rect_x),
        .i_rect_y   (i_rect_y),
        .i_rect_w   (i_rect_w),
        .i_rect_h   (i_rect_h),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hit      (o_hit),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #LIMIT_NS;
        $display("FAIL tile_map_rect_collision");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Clamp a tile span to [0, count-1]; return 0 when nothing is left
    function automatic bit clamp_span(inout int lo, inout int hi, input int count);
        if (count == 0)
            return 1'b0;
        if (lo < 0)
            lo = 0;
        if (hi > count - 1)
            hi = count - 1;
        return lo <= hi;
    endfunction

    // Work out whether the probe rectangle covers any solid tile
    function automatic logic probe_covers_solid(input t_tile_word wd);
        int   left, right, top, bottom, rows, cols;
        logic found;
        // SV integer division truncates toward zero, which is what is wanted
        left   = int'(wd.x) / TILE_PX;
        right  = (int'(wd.x) + int'(wd.w)) / TILE_PX;
        top    = int'(wd.y) / TILE_PX;
        bottom = (int'(wd.y) + int'(wd.h)) / TILE_PX;
        rows   = (rows_cfg > N_ROWS) ? N_ROWS : int'(rows_cfg);
        cols   = (cols_cfg > N_COLS) ? N_COLS : int'(cols_cfg);
        found  = 1'b0;
        if (clamp_span(left, right, cols) && clamp_span(top, bottom, rows)) begin
            for (int c = left; c <= right && !found; c++) begin
                for (int r = top; r <= bottom; r++) begin
                    if (solid_tiles[r][c])
                        found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    // Apply an accepted word to the shadow map, or queue the probe's hit
    task automatic record_word(input t_tile_word wd);
        t_hit_expect exp_hit;
        if (wd.action == tmrc_pkg::ACT_WRITE) begin
            solid_tiles[wd.row][wd.col] = (wd.id != '0);
        end else begin
            exp_hit.hit      = probe_covers_solid(wd);
            exp_hit.probe_no = probe_count++;
            pending_hits.push_back(exp_hit);
        end
    endtask

    function automatic t_tile_word make_write(input int row, input int col, input int id);
        t_tile_word wd;
        wd.action = tmrc_pkg::ACT_WRITE;
        wd.row    = tmrc_pkg::TROW_W'(row);
        wd.col    = tmrc_pkg::TCOL_W'(col);
        wd.id     = tmrc_pkg::TID_W'(id);
        // rectangle fields are don't-care on a write; keep them moving
        wd.x      = tmrc_pkg::POS_W'($urandom);
        wd.y      = tmrc_pkg::POS_W'($urandom);
        wd.w      = tmrc_pkg::SIZE_W'($urandom);
        wd.h      = tmrc_pkg::SIZE_W'($urandom);
        return wd;
    endfunction

    function automatic t_tile_word make_probe(input int x, input int y, input int w,
                                              input int h);
        t_tile_word wd;
        wd.action = tmrc_pkg::ACT_PROBE;
        wd.row    = tmrc_pkg::TROW_W'($urandom);
        wd.col    = tmrc_pkg::TCOL_W'($urandom);
        wd.id     = tmrc_pkg::TID_W'($urandom);
        wd.x      = tmrc_pkg::POS_W'(x);
        wd.y      = tmrc_pkg::POS_W'(y);
        wd.w      = tmrc_pkg::SIZE_W'(w);
        wd.h      = tmrc_pkg::SIZE_W'(h);
        return wd;
    endfunction

    // Mostly writes and small probes around the top-left corner, so hits and
    // misses both turn up; a few full-range and full-size probes
    function automatic t_tile_word random_word();
        int sel;
        int id;
        sel = $urandom_range(99);
        id  = ($urandom_range(99) < 30) ? 0 : int'($urandom_range(65535, 1));
        if (sel < 40) begin
            if ($urandom_range(99) < 60)
                return make_write($urandom_range(15), $urandom_range(31), id);
            return make_write($urandom, $urandom, id);
        end
        if (sel < 42)
            return make_probe($urandom, $urandom, $urandom_range(4095), $urandom_range(4095));
        if (sel < 43)
            return make_probe(int'($urandom_range(1100)) - 64, int'($urandom_range(600)) - 64,
                              $urandom_range(4095), $urandom_range(4095));
        if (sel < 50)
            return make_probe($urandom, $urandom, $urandom_range(96), $urandom_range(96));
        return make_probe(int'($urandom_range(1100)) - 64, int'($urandom_range(600)) - 64,
                          $urandom_range(80), $urandom_range(80));
    endfunction

    // Offer one word, at times after a random gap, and hold until taken
    task automatic send_word(input t_tile_word wd);
        if (!calm && $urandom_range(99) < 19) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_action   <= wd.action;
        i_tile_row <= wd.row;
        i_tile_col <= wd.col;
        i_tile_id  <= wd.id;
        i_rect_x   <= wd.x;
        i_rect_y   <= wd.y;
        i_rect_w   <= wd.w;
        i_rect_h   <= wd.h;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        record_word(wd);
    endtask

    // Drop valid and wait until every probe has answered and the block settles
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tmrc_pkg::PADDR_W'(idx) << tmrc_pkg::REG_BIT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx == tmrc_pkg::REG_ROWS_USED)
            rows_cfg = value[tmrc_pkg::ROWS_W-1:0];
        else
            cols_cfg = value[tmrc_pkg::COLS_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_map_size(input int unsigned rows, input int unsigned cols);
        wait_for_results();
        write_reg(tmrc_pkg::REG_ROWS_USED, rows);
        write_reg(tmrc_pkg::REG_COLS_USED, cols);
    endtask

    // Empty map after reset: full-size probes find nothing
    task automatic test_cleared_map();
        send_word(make_probe(0, 0, 4095, 4095));
        send_word(make_probe(-32768, -32768, 4095, 4095));
    endtask

    // Solid, clearing and out-of-area writes under the reset map size
    task automatic test_tile_writes();
        send_word(make_write(0, 0, 1));
        send_word(make_write(22, 239, 16'hFFFF));
        send_word(make_write(31, 255, 16'h8000));
        send_word(make_write(5, 100, 7));
        send_word(make_write(5, 100, 0));
        send_word(make_probe(0, 0, 0, 0));
        send_word(make_probe(239 * TILE_PX + 31, 22 * TILE_PX + 31, 0, 0));
        send_word(make_probe(100 * TILE_PX, 5 * TILE_PX, 31, 31));
        // kept in the store but outside the active map
        send_word(make_probe(255 * TILE_PX, 31 * TILE_PX, 0, 0));
    endtask

    // Negative edges truncate toward zero; spans wholly off the map are empty
    task automatic test_truncation_and_clamp();
        send_word(make_probe(-1, -1, 0, 0));
        send_word(make_probe(-31, -31, 0, 0));
        send_word(make_probe(-33, -33, 0, 0));
        send_word(make_probe(-40, -40, 8, 8));
        send_word(make_probe(-32768, 0, 0, 0));
        send_word(make_probe(32767, 32767, 4095, 4095));
    endtask

    // Zero counts, counts above the store, single tile and full map
    task automatic test_map_size_registers();
        set_map_size(0, 240);
        send_word(make_probe(0, 0, 0, 0));
        set_map_size(63, 511);
        send_word(make_probe(255 * TILE_PX, 31 * TILE_PX, 0, 0));
        set_map_size(23, 0);
        send_word(make_probe(0, 0, 4095, 4095));
        set_map_size(1, 1);
        send_word(make_probe(0, 0, 4095, 4095));
        send_word(make_probe(TILE_PX, 0, 0, 0));
        set_map_size(N_ROWS, N_COLS);
        send_word(make_probe(255 * TILE_PX, 31 * TILE_PX, 31, 31));
        set_map_size(tmrc_pkg::ROWS_RESET, tmrc_pkg::COLS_RESET);
    endtask

    // Hold the result side off long enough for the block to stall its input
    task automatic test_backpressure();
        wait_for_results();
        rx_hold = 300;
        repeat (40) send_word(random_word());
        wait_for_results();
    endtask

    // Random traffic over several map sizes, one phase without idling
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_map_size(tmrc_pkg::ROWS_RESET, tmrc_pkg::COLS_RESET);
                1: set_map_size(N_ROWS, N_COLS);
                2: set_map_size($urandom_range(40, 1), $urandom_range(300, 1));
                3: set_map_size(63, 511);
                default: set_map_size($urandom_range(16, 1), $urandom_range(40, 1));
            endcase
            calm = (phase == 1);
            repeat (PHASE_WORDS) send_word(random_word());
        end
        calm = 1'b0;
    endtask

    // Receiver side: hold-off first, then random stalls unless calm
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 19);
        end
    end

    // Check each result word against the oldest predicted hit
    always @(posedge i_clk) begin
        t_hit_expect exp_hit;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("result word hit=%b with no probe waiting", o_hit));
            end else begin
                exp_hit = pending_hits.pop_front();
                if (o_hit !== exp_hit.hit)
                    report_mismatch($sformatf("probe %0d: hit %b, expected %b",
                                              exp_hit.probe_no, o_hit, exp_hit.hit));
            end
        end
    end

    initial begin
        foreach (solid_tiles[r])
            solid_tiles[r] = '0;
        rows_cfg = tmrc_pkg::ROWS_RESET;
        cols_cfg = tmrc_pkg::COLS_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_map();
        test_tile_writes();
        test_truncation_and_clamp();
        test_map_size_registers();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        if (mismatches == 0)
            $display("PASS tile_map_rect_collision");
        else
            $display("FAIL tile_map_rect_collision");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tmrc_pkg.sv
hdl/tmrc_ram.sv
hdl/tmrc_axis.sv
hdl/tile_map_rect_collision.sv
verif/tile_map_rect_collision_tb.sv
